### hdl/swdd_pkg.sv
// Shared types and constants for the sliding window distinct detector.
// Used by every module of the block but swdd_ram; depends on nothing.
package swdd_pkg;

   localparam int LETTER_W    = 5;
   localparam int NUM_LETTERS = 26;
   localparam logic [LETTER_W-1:0] LAST_CODE = 5'd25;

   localparam int COUNT_W = 6;
   localparam int DUP_W   = 5;
   localparam int POS_W   = 17;

   localparam int WSIZE_W = 6;
   localparam logic [WSIZE_W-1:0] WSIZE_RESET = 6'd14;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   // Word index of the window size register (byte address 0).
   localparam logic REG_WINDOW_SIZE = 1'b0;

   localparam int OUTQ_DEPTH = 4;
   localparam int QPTR_W     = $clog2(OUTQ_DEPTH);
   localparam int QCNT_W     = $clog2(OUTQ_DEPTH + 1);

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                last;
      logic                evict;
      logic                full;
   } item_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } result_type;

endpackage

### hdl/swdd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during write to the same address returns the old contents. No dependencies.
module swdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/swdd_window.sv
// Front stage: ring of recent letters, write pointer, fill level and the
// window length latched per stream. Depends on swdd_pkg and swdd_ram.
module swdd_window
   import swdd_pkg::*;
#(
   parameter int MAX_WINDOW = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [LETTER_W-1:0]                letter,
   input  logic                               last_letter,
   input  logic [WSIZE_W-1:0]                 window_size,
   output logic                               s1_valid,
   output item_type                           s1_item,
   output logic [$clog2(MAX_WINDOW + 1)-1:0]  s1_win,
   output logic [LETTER_W-1:0]                s1_old
);

   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int RW    = $clog2(MAX_WINDOW);
   localparam int EXT_W = (WIN_W > WSIZE_W) ? WIN_W : WSIZE_W;

   logic [RW-1:0]       wr_ff, wr_in;
   logic [WIN_W-1:0]    fill_ff, fill_in;
   logic [WIN_W-1:0]    win_ff, win_in;
   logic                s1_valid_ff;
   item_type            s1_item_ff;
   logic [WIN_W-1:0]    s1_win_ff;

   logic [EXT_W-1:0]    ws_ext;
   logic [WIN_W-1:0]    win_eff;
   logic [WIN_W-1:0]    cur_win;
   logic [WIN_W-1:0]    fill_next;
   logic [WIN_W:0]      slot_sum;
   logic [WIN_W:0]      slot_wrap;
   logic [RW-1:0]       slot;
   logic [LETTER_W-1:0] letter_c;
   item_type            item;

   // Clamp the register: zero acts as one, above the ring depth acts as the depth.
   always_comb begin
      ws_ext = EXT_W'(window_size);
      if (ws_ext == '0) begin
         win_eff = WIN_W'(1);
      end else if (ws_ext > EXT_W'(MAX_WINDOW)) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = WIN_W'(ws_ext);
      end
   end

   assign cur_win   = (fill_ff == '0) ? win_eff : win_ff;
   assign fill_next = (fill_ff == WIN_W'(MAX_WINDOW)) ? fill_ff : fill_ff + WIN_W'(1);
   assign letter_c  = (letter > LAST_CODE) ? LAST_CODE : letter;

   // Slot of the letter leaving the window: (wr - win) modulo ring depth.
   always_comb begin
      slot_sum  = (WIN_W + 1)'(wr_ff) + (WIN_W + 1)'(MAX_WINDOW) - (WIN_W + 1)'(cur_win);
      slot_wrap = (slot_sum >= (WIN_W + 1)'(MAX_WINDOW)) ?
                  slot_sum - (WIN_W + 1)'(MAX_WINDOW) : slot_sum;
      slot      = RW'(slot_wrap);
   end

   always_comb begin
      item.letter = letter_c;
      item.last   = last_letter;
      item.evict  = (fill_ff >= cur_win);
      item.full   = (fill_next >= cur_win);
   end

   always_comb begin
      wr_in   = wr_ff;
      fill_in = fill_ff;
      win_in  = win_ff;
      if (accept) begin
         if (last_letter) begin
            wr_in   = '0;
            fill_in = '0;
         end else begin
            wr_in   = (wr_ff == RW'(MAX_WINDOW - 1)) ? '0 : wr_ff + RW'(1);
            fill_in = fill_next;
            win_in  = cur_win;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff       <= '0;
         fill_ff     <= '0;
         win_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wr_ff       <= wr_in;
         fill_ff     <= fill_in;
         win_ff      <= win_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= item;
         s1_win_ff  <= cur_win;
      end
   end

   swdd_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (MAX_WINDOW)
   ) ring_ram (
      .clock (clock),
      .we    (accept),
      .waddr (wr_ff),
      .wdata (letter_c),
      .raddr (slot),
      .rdata (s1_old)
   );

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;
   assign s1_win   = s1_win_ff;

endmodule

### hdl/swdd_count.sv
// Count stage: per-letter counts kept as add and remove tallies in RAM,
// duplicate tracking, stream index and the hit decision. Depends on swdd_pkg, swdd_ram.
module swdd_count
   import swdd_pkg::*;
#(
   parameter int MAX_WINDOW = 32,
   parameter int MAX_LENGTH = 65535
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               s1_valid,
   input  item_type                           s1_item,
   input  logic [$clog2(MAX_WINDOW + 1)-1:0]  s1_win,
   input  logic [LETTER_W-1:0]                s1_old,
   output logic                               s2_valid,
   output logic                               push,
   output result_type                         push_data
);

   localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W   = $clog2(MAX_LENGTH + 2);
   localparam int CAP_W   = (IDX_W > POS_W) ? IDX_W : POS_W;
   localparam int POS_CAP = (MAX_LENGTH + 1 < (1 << POS_W) - 1) ?
                            MAX_LENGTH + 1 : (1 << POS_W) - 1;

   logic                   s2_valid_ff;
   item_type               s2_item_ff;
   logic [WIN_W-1:0]       s2_win_ff;
   logic [LETTER_W-1:0]    s2_old_ff;

   logic [DUP_W-1:0]       dup_ff, dup_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   reported_ff, reported_in;
   logic [NUM_LETTERS-1:0] inc_vld_ff, inc_vld_in;
   logic [NUM_LETTERS-1:0] dec_vld_ff, dec_vld_in;
   logic                   byp_inc_v_ff;
   logic [LETTER_W-1:0]    byp_inc_addr_ff;
   logic [COUNT_W-1:0]     byp_inc_data_ff;
   logic                   byp_dec_v_ff;
   logic [LETTER_W-1:0]    byp_dec_addr_ff;
   logic [COUNT_W-1:0]     byp_dec_data_ff;

   logic [LETTER_W-1:0]    old_c;
   logic [COUNT_W-1:0]     inc_l_rd, inc_o_rd, dec_l_rd, dec_o_rd;
   logic [COUNT_W-1:0]     inc_l, inc_o, dec_l, dec_o;
   logic [COUNT_W-1:0]     c_l, c_l_new, c_o;
   logic [COUNT_W-1:0]     inc_l_new, dec_o_new;
   logic                   c_l_sat;
   logic                   dup_up, dup_down, dec_do;
   logic [DUP_W-1:0]       dup_mid, dup_new;
   logic                   proc, hit;
   logic                   inc_we, dec_we;
   logic [IDX_W-1:0]       idx1, idx_next, start, miss_pos;
   logic [CAP_W-1:0]       pos_raw, pos_cap;

   function automatic logic [COUNT_W-1:0] fwd(
      input logic                   byp_v,
      input logic [LETTER_W-1:0]    byp_addr,
      input logic [COUNT_W-1:0]     byp_data,
      input logic [LETTER_W-1:0]    addr,
      input logic [NUM_LETTERS-1:0] vld,
      input logic [COUNT_W-1:0]     rd
   );
      logic [COUNT_W-1:0] val;
      val = '0;
      if (byp_v && byp_addr == addr) begin
         val = byp_data;
      end else if (vld[addr]) begin
         val = rd;
      end
      return val;
   endfunction

   // S1: issue tally reads for the incoming letter and the leaving letter.
   assign old_c = (s1_old > LAST_CODE) ? LAST_CODE : s1_old;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid) begin
         s2_item_ff <= s1_item;
         s2_win_ff  <= s1_win;
         s2_old_ff  <= old_c;
      end
   end

   swdd_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_LETTERS)) inc_l_ram (
      .clock (clock), .we (inc_we), .waddr (s2_item_ff.letter), .wdata (inc_l_new),
      .raddr (s1_item.letter), .rdata (inc_l_rd)
   );
   // Replica of the add tallies for the second read address.
   swdd_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_LETTERS)) inc_o_ram (
      .clock (clock), .we (inc_we), .waddr (s2_item_ff.letter), .wdata (inc_l_new),
      .raddr (old_c), .rdata (inc_o_rd)
   );
   swdd_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_LETTERS)) dec_l_ram (
      .clock (clock), .we (dec_we), .waddr (s2_old_ff), .wdata (dec_o_new),
      .raddr (s1_item.letter), .rdata (dec_l_rd)
   );
   swdd_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_LETTERS)) dec_o_ram (
      .clock (clock), .we (dec_we), .waddr (s2_old_ff), .wdata (dec_o_new),
      .raddr (old_c), .rdata (dec_o_rd)
   );

   // S2: forward last cycle's write, then count = adds - removes (mod 2^COUNT_W).
   always_comb begin
      inc_l = fwd(byp_inc_v_ff, byp_inc_addr_ff, byp_inc_data_ff,
                  s2_item_ff.letter, inc_vld_ff, inc_l_rd);
      dec_l = fwd(byp_dec_v_ff, byp_dec_addr_ff, byp_dec_data_ff,
                  s2_item_ff.letter, dec_vld_ff, dec_l_rd);
      inc_o = fwd(byp_inc_v_ff, byp_inc_addr_ff, byp_inc_data_ff,
                  s2_old_ff, inc_vld_ff, inc_o_rd);
      dec_o = fwd(byp_dec_v_ff, byp_dec_addr_ff, byp_dec_data_ff,
                  s2_old_ff, dec_vld_ff, dec_o_rd);

      c_l       = inc_l - dec_l;
      c_l_sat   = (c_l == '1);
      inc_l_new = c_l_sat ? inc_l : inc_l + COUNT_W'(1);
      c_l_new   = c_l_sat ? c_l : c_l + COUNT_W'(1);
      dup_up    = (c_l == COUNT_W'(1));
      dup_mid   = dup_ff + DUP_W'(dup_up);

      // Leaving letter sees the increment when it equals the incoming one.
      c_o       = (s2_old_ff == s2_item_ff.letter) ? c_l_new : inc_o - dec_o;
      dec_do    = s2_item_ff.evict && (c_o != '0);
      dec_o_new = dec_o + COUNT_W'(1);
      dup_down  = dec_do && (c_o == COUNT_W'(2)) && (dup_mid != '0);
      dup_new   = dup_mid - DUP_W'(dup_down);
   end

   assign proc   = s2_valid_ff && !reported_ff;
   assign hit    = proc && s2_item_ff.full && (dup_new == '0);
   assign inc_we = proc && !s2_item_ff.last;
   assign dec_we = inc_we && dec_do;

   always_comb begin
      idx1     = idx_ff + IDX_W'(1);
      start    = (idx1 >= IDX_W'(s2_win_ff)) ? idx1 - IDX_W'(s2_win_ff) : '0;
      idx_next = (proc && idx_ff < IDX_W'(MAX_LENGTH)) ? idx1 : idx_ff;
      miss_pos = idx_next + IDX_W'(1);
      pos_raw  = hit ? CAP_W'(start) : CAP_W'(miss_pos);
      pos_cap  = (pos_raw > CAP_W'(POS_CAP)) ? CAP_W'(POS_CAP) : pos_raw;
   end

   assign push               = hit || (proc && s2_item_ff.last);
   assign push_data.found    = hit;
   assign push_data.position = POS_W'(pos_cap);

   always_comb begin
      dup_in      = dup_ff;
      idx_in      = idx_ff;
      reported_in = reported_ff;
      inc_vld_in  = inc_vld_ff;
      dec_vld_in  = dec_vld_ff;
      if (s2_valid_ff && s2_item_ff.last) begin
         // End of stream: drop all tallies at once.
         dup_in      = '0;
         idx_in      = '0;
         reported_in = 1'b0;
         inc_vld_in  = '0;
         dec_vld_in  = '0;
      end else if (proc) begin
         dup_in      = dup_new;
         idx_in      = idx_next;
         reported_in = hit;
         inc_vld_in[s2_item_ff.letter] = 1'b1;
         if (dec_we) begin
            dec_vld_in[s2_old_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dup_ff       <= '0;
         idx_ff       <= '0;
         reported_ff  <= 1'b0;
         inc_vld_ff   <= '0;
         dec_vld_ff   <= '0;
         byp_inc_v_ff <= 1'b0;
         byp_dec_v_ff <= 1'b0;
      end else begin
         dup_ff       <= dup_in;
         idx_ff       <= idx_in;
         reported_ff  <= reported_in;
         inc_vld_ff   <= inc_vld_in;
         dec_vld_ff   <= dec_vld_in;
         byp_inc_v_ff <= inc_we;
         byp_dec_v_ff <= dec_we;
      end
   end

   always_ff @(posedge clock) begin
      byp_inc_addr_ff <= s2_item_ff.letter;
      byp_inc_data_ff <= inc_l_new;
      byp_dec_addr_ff <= s2_old_ff;
      byp_dec_data_ff <= dec_o_new;
   end

   assign s2_valid = s2_valid_ff;

endmodule

### hdl/swdd_outq.sv
// Small result queue that decouples the count stage from the response channel.
// Depends on swdd_pkg.
module swdd_outq
   import swdd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  result_type        push_data,
   input  logic              pop,
   output logic              out_valid,
   output result_type        out_data,
   output logic [QCNT_W-1:0] count
);

   result_type        entry_ff [OUTQ_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              pop_ok;

   assign pop_ok = pop && (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(pop_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = cnt_ff;

endmodule

### hdl/sliding_window_distinct_detector.sv
// Sliding window distinct detector: takes one letter request per cycle, back to back, while
// req_ready is high, and reports the start of the first window of window_size letters that
// holds no repeated letter, once per stream; a stream that ends without one reports length
// plus one. For each accepted request the ring of recent letters is read first, then the
// per-letter tally memories, each with a registered read. Up to four results queue on the
// response side; req_ready drops only when queued results plus requests in flight reach
// four. Tallies clear at once at the end of a stream and at reset (no clearing pass). A
// window_size write applies from the next stream.
module sliding_window_distinct_detector
   import swdd_pkg::*;
#(
   parameter int MAX_WINDOW = 32,
   parameter int MAX_LENGTH = 65535
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LETTER_W-1:0]   req_letter,
   input  logic                  req_last_letter,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [POS_W-1:0]      rsp_position,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int WIN_W = $clog2(MAX_WINDOW + 1);

   logic [WSIZE_W-1:0] window_size_ff;
   logic               csr_sel_win;
   logic               accept;
   logic               s1_valid, s2_valid;
   item_type           s1_item;
   logic [WIN_W-1:0]   s1_win;
   logic [LETTER_W-1:0] s1_old;
   logic               push;
   result_type         push_data;
   result_type         rsp_data;
   logic [QCNT_W-1:0]  q_cnt;
   logic [QCNT_W-1:0]  pending;

   // Configuration register
   assign csr_sel_win = (csr_paddr[2] == REG_WINDOW_SIZE);
   assign csr_pready  = 1'b1;
   assign csr_prdata  = csr_sel_win ? CSR_DATA_W'(window_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WSIZE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel_win) begin
         window_size_ff <= csr_pwdata[WSIZE_W-1:0];
      end
   end

   // Hold requests while every queue slot is spoken for.
   assign pending   = q_cnt + QCNT_W'(s1_valid) + QCNT_W'(s2_valid);
   assign req_ready = (pending < QCNT_W'(OUTQ_DEPTH));
   assign accept    = req_valid && req_ready;

   swdd_window #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .letter      (req_letter),
      .last_letter (req_last_letter),
      .window_size (window_size_ff),
      .s1_valid    (s1_valid),
      .s1_item     (s1_item),
      .s1_win      (s1_win),
      .s1_old      (s1_old)
   );

   swdd_count #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_LENGTH (MAX_LENGTH)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .s1_win    (s1_win),
      .s1_old    (s1_old),
      .s2_valid  (s2_valid),
      .push      (push),
      .push_data (push_data)
   );

   swdd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (q_cnt)
   );

   assign rsp_found    = rsp_data.found;
   assign rsp_position = rsp_data.position;

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= QCNT_W'(OUTQ_DEPTH))
      else $error("queued plus in-flight results exceed queue depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_cnt != QCNT_W'(OUTQ_DEPTH)) || (rsp_valid && rsp_ready))
      else $error("result pushed into a full queue");

   a_win_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid |-> (s1_win != '0) && (s1_win <= WIN_W'(MAX_WINDOW)))
      else $error("latched window length out of range");

endmodule
